/* src/auto_task_mode_sequencer_defines.svh */
// Assertion macros shared by the mode sequencer RTL.
// Self-contained; included by the files that carry assertions.
`ifndef AUTO_TASK_MODE_SEQUENCER_DEFINES_SVH
`define AUTO_TASK_MODE_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ATMS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define ATMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* src/atms_pkg.sv */
// Types and codes for the auto task mode sequencer.
// No dependencies.
`default_nettype none

package atms_pkg;

    typedef enum logic [2:0] {
        FUNC_TICK       = 3'd0,
        FUNC_PAUSE      = 3'd1,
        FUNC_RESUME     = 3'd2,
        FUNC_STOP       = 3'd3,
        FUNC_RESTART    = 3'd4,
        FUNC_RESET      = 3'd5,
        FUNC_PM_START   = 3'd6,
        FUNC_PM_STOP    = 3'd7
    } func_t;

    typedef enum logic [2:0] {
        MODE_MOVING   = 3'd0,
        MODE_PAUSING  = 3'd1,
        MODE_PAUSED   = 3'd2,
        MODE_RESUMING = 3'd3,
        MODE_STOPPING = 3'd4,
        MODE_STOPPED  = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        TS_RUNNING  = 3'd0,
        TS_PAUSING  = 3'd1,
        TS_PAUSED   = 3'd2,
        TS_STOPPING = 3'd3,
        TS_STOPPED  = 3'd4
    } tstat_t;

    typedef enum logic [1:0] {
        TCALL_NONE   = 2'd0,
        TCALL_PAUSE  = 2'd1,
        TCALL_STOP   = 2'd2,
        TCALL_RESUME = 2'd3
    } tcall_t;

    typedef enum logic [2:0] {
        CCALL_NONE      = 3'd0,
        CCALL_PAUSE_REC = 3'd1,
        CCALL_RESUME_REC = 3'd2,
        CCALL_ACTIVATE  = 3'd3,
        CCALL_STOP      = 3'd4,
        CCALL_INIT      = 3'd5,
        CCALL_PM_START  = 3'd6,
        CCALL_PM_STOP   = 3'd7
    } ccall_t;

    typedef enum logic [1:0] {
        SIG_NONE    = 2'd0,
        SIG_PAUSED  = 2'd1,
        SIG_RESUMED = 2'd2,
        SIG_STOPPED = 2'd3
    } sig_t;

    // owner encoding
    localparam logic OWNER_TASK     = 1'b0;
    localparam logic OWNER_RECOVERY = 1'b1;

endpackage

`default_nettype wire

/* src/auto_task_mode_sequencer.sv */
// Auto task mode sequencer: one-item-per-cycle command decoder (while results are taken) and mode state.
// Depends on atms_pkg and auto_task_mode_sequencer_defines.svh.
//
// Usage:
//   Input channel (s_valid/s_ready) carries one command word per item:
//   func plus the task and recovery controller status and ack flags.
//   Result channel (m_valid/m_ready) returns one word per command: ok,
//   step strobes, task and controller calls, stop_now, signal_out and the
//   run mode and owner after the command.
//   A word lands in the input register on acceptance, then decodes into
//   the result register once that register is free. Throughput is one
//   word per cycle while m_ready takes the results; the decode is a
//   single pass of small logic over the mode state.
//   Mode, owner and task-present flags update when a word moves from the
//   input register to the result register.
//   Reset (aresetn low, synchronous) empties both registers and returns to
//   no task, stopped mode, task owner.
//   When m_ready is low, the result holds; the input register still takes
//   one more word, then s_ready drops until the result is taken.
`default_nettype none

`include "auto_task_mode_sequencer_defines.svh"

module auto_task_mode_sequencer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [2:0] s_func,
    input  wire logic [2:0] s_task_status,
    input  wire logic       s_task_ack,
    input  wire logic       s_ctrl_ack,
    input  wire logic       s_ctrl_stopped,
    input  wire logic       s_ctrl_recover_over,
    input  wire logic       s_ctrl_recover_paused,
    input  wire logic       s_immediate_stop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_ok,
    output logic            m_task_step,
    output logic            m_ctrl_step,
    output logic [1:0]      m_task_call,
    output logic [2:0]      m_ctrl_call,
    output logic            m_stop_now,
    output logic [1:0]      m_signal_out,
    output logic [2:0]      m_mode_out,
    output logic            m_owner_out
);

    // input register
    logic                 in_valid_reg;
    atms_pkg::func_t      in_func_reg;
    atms_pkg::tstat_t     in_ts_reg;
    logic                 in_task_ack_reg;
    logic                 in_ctrl_ack_reg;
    logic                 in_c_stop_reg;
    logic                 in_c_over_reg;
    logic                 in_c_pau_reg;
    logic                 in_imm_reg;

    // mode state
    logic                 present_reg, present_next;
    atms_pkg::mode_t      mode_reg, mode_next;
    logic                 owner_reg, owner_next;

    // result register
    logic                 m_valid_reg;
    logic                 ok_reg, ok_next;
    logic                 task_step_reg, task_step_next;
    logic                 ctrl_step_reg, ctrl_step_next;
    atms_pkg::tcall_t     task_call_reg, task_call_next;
    atms_pkg::ccall_t     ctrl_call_reg, ctrl_call_next;
    logic                 stop_now_reg, stop_now_next;
    atms_pkg::sig_t       signal_reg, signal_next;

    logic out_free;
    logic adv;

    assign out_free = !m_valid_reg || m_ready;
    assign adv      = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || adv;

    always_comb begin
        present_next   = present_reg;
        mode_next      = mode_reg;
        owner_next     = owner_reg;
        ok_next        = 1'b0;
        task_step_next = 1'b0;
        ctrl_step_next = 1'b0;
        task_call_next = atms_pkg::TCALL_NONE;
        ctrl_call_next = atms_pkg::CCALL_NONE;
        stop_now_next  = 1'b0;
        signal_next    = atms_pkg::SIG_NONE;

        unique case (in_func_reg)
            atms_pkg::FUNC_TICK: begin
                if (present_reg && owner_reg == atms_pkg::OWNER_RECOVERY) begin
                    priority case (mode_reg)
                        atms_pkg::MODE_MOVING: begin
                            ctrl_step_next = 1'b1;
                            if (in_c_stop_reg) begin
                                signal_next = atms_pkg::SIG_STOPPED;
                                mode_next   = atms_pkg::MODE_STOPPED;
                            end else if (in_c_over_reg) begin
                                task_call_next = atms_pkg::TCALL_RESUME;
                                if (in_task_ack_reg) begin
                                    owner_next = atms_pkg::OWNER_TASK;
                                    mode_next  = atms_pkg::MODE_RESUMING;
                                end
                            end
                        end
                        atms_pkg::MODE_PAUSING: begin
                            ctrl_step_next = 1'b1;
                            if (in_c_pau_reg) begin
                                signal_next = atms_pkg::SIG_PAUSED;
                                mode_next   = atms_pkg::MODE_PAUSED;
                            end
                        end
                        atms_pkg::MODE_STOPPING: begin
                            ctrl_step_next = 1'b1;
                            if (in_c_stop_reg) begin
                                signal_next = atms_pkg::SIG_STOPPED;
                                mode_next   = atms_pkg::MODE_STOPPED;
                                owner_next  = atms_pkg::OWNER_TASK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (present_reg) begin
                    priority case (mode_reg)
                        atms_pkg::MODE_MOVING: begin
                            task_step_next = 1'b1;
                            if (in_ts_reg == atms_pkg::TS_PAUSING ||
                                in_ts_reg == atms_pkg::TS_PAUSED) begin
                                mode_next = atms_pkg::MODE_PAUSING;
                            end else if (in_ts_reg == atms_pkg::TS_STOPPING ||
                                         in_ts_reg == atms_pkg::TS_STOPPED) begin
                                mode_next = atms_pkg::MODE_STOPPING;
                            end
                        end
                        atms_pkg::MODE_PAUSING: begin
                            task_step_next = 1'b1;
                            if (in_ts_reg == atms_pkg::TS_PAUSED) begin
                                signal_next    = atms_pkg::SIG_PAUSED;
                                ctrl_call_next = atms_pkg::CCALL_INIT;
                                mode_next      = atms_pkg::MODE_PAUSED;
                            end else if (in_ts_reg == atms_pkg::TS_STOPPING ||
                                         in_ts_reg == atms_pkg::TS_STOPPED) begin
                                mode_next = atms_pkg::MODE_STOPPING;
                            end else if (in_ts_reg == atms_pkg::TS_RUNNING) begin
                                mode_next = atms_pkg::MODE_RESUMING;
                            end
                        end
                        atms_pkg::MODE_PAUSED: begin
                            ctrl_step_next = 1'b1;
                        end
                        atms_pkg::MODE_RESUMING: begin
                            task_step_next = 1'b1;
                            if (in_ts_reg == atms_pkg::TS_RUNNING) begin
                                signal_next = atms_pkg::SIG_RESUMED;
                                mode_next   = atms_pkg::MODE_MOVING;
                            end else if (in_ts_reg == atms_pkg::TS_STOPPING ||
                                         in_ts_reg == atms_pkg::TS_STOPPED) begin
                                signal_next = atms_pkg::SIG_RESUMED;
                                mode_next   = atms_pkg::MODE_STOPPING;
                            end else if (in_ts_reg == atms_pkg::TS_PAUSING ||
                                         in_ts_reg == atms_pkg::TS_PAUSED) begin
                                mode_next = atms_pkg::MODE_PAUSING;
                            end
                        end
                        atms_pkg::MODE_STOPPING: begin
                            task_step_next = 1'b1;
                            if (in_ts_reg == atms_pkg::TS_STOPPED) begin
                                signal_next = atms_pkg::SIG_STOPPED;
                                mode_next   = atms_pkg::MODE_STOPPED;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            atms_pkg::FUNC_PAUSE: begin
                if (present_reg && owner_reg == atms_pkg::OWNER_RECOVERY) begin
                    if (mode_reg == atms_pkg::MODE_PAUSED ||
                        mode_reg == atms_pkg::MODE_PAUSING) begin
                        ok_next = 1'b1;
                    end else if (mode_reg == atms_pkg::MODE_MOVING) begin
                        ctrl_call_next = atms_pkg::CCALL_PAUSE_REC;
                        ok_next        = in_ctrl_ack_reg;
                        if (in_ctrl_ack_reg) begin
                            mode_next = atms_pkg::MODE_PAUSING;
                        end
                    end
                end else if (present_reg) begin
                    if (mode_reg == atms_pkg::MODE_MOVING ||
                        mode_reg == atms_pkg::MODE_RESUMING) begin
                        task_call_next = atms_pkg::TCALL_PAUSE;
                        ok_next        = in_task_ack_reg;
                        if (in_task_ack_reg) begin
                            mode_next = atms_pkg::MODE_PAUSING;
                        end
                    end else if (mode_reg == atms_pkg::MODE_PAUSING ||
                                 mode_reg == atms_pkg::MODE_PAUSED) begin
                        ok_next = 1'b1;
                    end
                end
            end

            atms_pkg::FUNC_RESUME: begin
                if (present_reg && owner_reg == atms_pkg::OWNER_RECOVERY) begin
                    if (mode_reg == atms_pkg::MODE_MOVING) begin
                        ok_next = 1'b1;
                    end else if (mode_reg == atms_pkg::MODE_PAUSED) begin
                        ctrl_call_next = atms_pkg::CCALL_RESUME_REC;
                        ok_next        = in_ctrl_ack_reg;
                        if (in_ctrl_ack_reg) begin
                            mode_next   = atms_pkg::MODE_MOVING;
                            signal_next = atms_pkg::SIG_RESUMED;
                        end
                    end
                end else if (present_reg) begin
                    if (mode_reg == atms_pkg::MODE_PAUSED) begin
                        // hand over to the recovery controller
                        ctrl_call_next = atms_pkg::CCALL_ACTIVATE;
                        ok_next        = in_ctrl_ack_reg;
                        if (in_ctrl_ack_reg) begin
                            owner_next  = atms_pkg::OWNER_RECOVERY;
                            mode_next   = atms_pkg::MODE_MOVING;
                            signal_next = atms_pkg::SIG_RESUMED;
                        end
                    end else if (mode_reg == atms_pkg::MODE_RESUMING) begin
                        ok_next = 1'b1;
                    end
                end
            end

            atms_pkg::FUNC_STOP: begin
                if (present_reg && owner_reg == atms_pkg::OWNER_RECOVERY) begin
                    if (mode_reg == atms_pkg::MODE_STOPPING) begin
                        ok_next = 1'b1;
                    end else if (mode_reg == atms_pkg::MODE_MOVING ||
                                 mode_reg == atms_pkg::MODE_PAUSING ||
                                 mode_reg == atms_pkg::MODE_PAUSED) begin
                        ctrl_call_next = atms_pkg::CCALL_STOP;
                        stop_now_next  = in_imm_reg;
                        ok_next        = in_ctrl_ack_reg;
                        if (in_ctrl_ack_reg) begin
                            mode_next = atms_pkg::MODE_STOPPING;
                        end
                    end
                end else if (present_reg) begin
                    if (mode_reg == atms_pkg::MODE_MOVING ||
                        mode_reg == atms_pkg::MODE_RESUMING ||
                        mode_reg == atms_pkg::MODE_PAUSING) begin
                        task_call_next = atms_pkg::TCALL_STOP;
                        stop_now_next  = in_imm_reg;
                        ok_next        = in_task_ack_reg;
                        if (in_task_ack_reg) begin
                            mode_next = atms_pkg::MODE_STOPPING;
                        end
                    end else if (mode_reg == atms_pkg::MODE_PAUSED) begin
                        mode_next = atms_pkg::MODE_STOPPED;
                        ok_next   = 1'b1;
                    end else if (mode_reg == atms_pkg::MODE_STOPPING ||
                                 mode_reg == atms_pkg::MODE_STOPPED) begin
                        ok_next = 1'b1;
                    end
                end
            end

            atms_pkg::FUNC_RESTART: begin
                present_next = 1'b1;
                mode_next    = atms_pkg::MODE_MOVING;
                owner_next   = atms_pkg::OWNER_TASK;
                ok_next      = 1'b1;
            end

            atms_pkg::FUNC_RESET: begin
                // owner is left as is
                present_next   = 1'b0;
                mode_next      = atms_pkg::MODE_STOPPED;
                ctrl_call_next = atms_pkg::CCALL_INIT;
            end

            atms_pkg::FUNC_PM_START: begin
                if (mode_reg == atms_pkg::MODE_PAUSED &&
                    owner_reg == atms_pkg::OWNER_TASK) begin
                    ctrl_call_next = atms_pkg::CCALL_PM_START;
                    ok_next        = in_ctrl_ack_reg;
                end
            end

            atms_pkg::FUNC_PM_STOP: begin
                if (mode_reg == atms_pkg::MODE_PAUSED &&
                    owner_reg == atms_pkg::OWNER_TASK) begin
                    ctrl_call_next = atms_pkg::CCALL_PM_STOP;
                    stop_now_next  = in_imm_reg;
                    ok_next        = in_ctrl_ack_reg;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            present_reg  <= 1'b0;
            mode_reg     <= atms_pkg::MODE_STOPPED;
            owner_reg    <= atms_pkg::OWNER_TASK;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                m_valid_reg <= in_valid_reg;
            end
            if (adv) begin
                present_reg <= present_next;
                mode_reg    <= mode_next;
                owner_reg   <= owner_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg     <= atms_pkg::func_t'(s_func);
            in_ts_reg       <= atms_pkg::tstat_t'(s_task_status);
            in_task_ack_reg <= s_task_ack;
            in_ctrl_ack_reg <= s_ctrl_ack;
            in_c_stop_reg   <= s_ctrl_stopped;
            in_c_over_reg   <= s_ctrl_recover_over;
            in_c_pau_reg    <= s_ctrl_recover_paused;
            in_imm_reg      <= s_immediate_stop;
        end
        if (adv) begin
            ok_reg        <= ok_next;
            task_step_reg <= task_step_next;
            ctrl_step_reg <= ctrl_step_next;
            task_call_reg <= task_call_next;
            ctrl_call_reg <= ctrl_call_next;
            stop_now_reg  <= stop_now_next;
            signal_reg    <= signal_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_ok         = ok_reg;
    assign m_task_step  = task_step_reg;
    assign m_ctrl_step  = ctrl_step_reg;
    assign m_task_call  = task_call_reg;
    assign m_ctrl_call  = ctrl_call_reg;
    assign m_stop_now   = stop_now_reg;
    assign m_signal_out = signal_reg;
    assign m_mode_out   = mode_reg;
    assign m_owner_out  = owner_reg;

    // restart always lands in moving mode with the task in charge
    `ATMS_ASSERT_NEXT(a_restart_state, aclk, aresetn,
        adv && in_func_reg == atms_pkg::FUNC_RESTART,
        present_reg && mode_reg == atms_pkg::MODE_MOVING &&
        owner_reg == atms_pkg::OWNER_TASK && m_valid && m_ok)

    // reset command clears the task and stops
    `ATMS_ASSERT_NEXT(a_reset_state, aclk, aresetn,
        adv && in_func_reg == atms_pkg::FUNC_RESET,
        !present_reg && mode_reg == atms_pkg::MODE_STOPPED &&
        m_ctrl_call == atms_pkg::CCALL_INIT && !m_ok)

    // state moves only with a word
    `ATMS_ASSERT_NEXT(a_state_hold, aclk, aresetn,
        !adv,
        $stable(present_reg) && $stable(mode_reg) && $stable(owner_reg))

    // a call to the task never comes with a task step
    `ATMS_ASSERT_NOW(a_call_no_step, aclk, aresetn,
        m_valid && m_task_call != atms_pkg::TCALL_NONE,
        !m_task_step)

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for auto_task_mode_sequencer: command words go in, one result word
// comes back per command and is checked against an in-bench model of the mode sequencer.
// Depends on atms_pkg and the auto_task_mode_sequencer RTL.

module testbench;
    import atms_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct packed {
        func_t      func;
        logic [2:0] task_status;
        logic       task_ack;
        logic       ctrl_ack;
        logic       ctrl_stopped;
        logic       ctrl_recover_over;
        logic       ctrl_recover_paused;
        logic       immediate_stop;
    } command_t;

    typedef struct packed {
        logic   ok;
        logic   task_step;
        logic   ctrl_step;
        tcall_t task_call;
        ccall_t ctrl_call;
        logic   stop_now;
        sig_t   signal_out;
        mode_t  mode_out;
        logic   owner_out;
    } outcome_t;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    command_t   s_cmd = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_ok;
    logic       m_task_step;
    logic       m_ctrl_step;
    logic [1:0] m_task_call;
    logic [2:0] m_ctrl_call;
    logic       m_stop_now;
    logic [1:0] m_signal_out;
    logic [2:0] m_mode_out;
    logic       m_owner_out;

    // model state of the sequencer
    logic  seq_task_present = 1'b0;
    mode_t seq_mode = MODE_STOPPED;
    logic  seq_owner = OWNER_TASK;

    command_t    command_q[$];
    outcome_t    outcome_q[$];
    int unsigned queued_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned sender_idle_pct = 12;
    int unsigned receiver_idle_pct = 49;

    auto_task_mode_sequencer uut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_func                (s_cmd.func),
        .s_task_status         (s_cmd.task_status),
        .s_task_ack            (s_cmd.task_ack),
        .s_ctrl_ack            (s_cmd.ctrl_ack),
        .s_ctrl_stopped        (s_cmd.ctrl_stopped),
        .s_ctrl_recover_over   (s_cmd.ctrl_recover_over),
        .s_ctrl_recover_paused (s_cmd.ctrl_recover_paused),
        .s_immediate_stop      (s_cmd.immediate_stop),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_ok                  (m_ok),
        .m_task_step           (m_task_step),
        .m_ctrl_step           (m_ctrl_step),
        .m_task_call           (m_task_call),
        .m_ctrl_call           (m_ctrl_call),
        .m_stop_now            (m_stop_now),
        .m_signal_out          (m_signal_out),
        .m_mode_out            (m_mode_out),
        .m_owner_out           (m_owner_out)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Advance the mode state by one command and return the result word it gives.
    function automatic outcome_t sequence_command(command_t c);
        outcome_t o;
        logic     ts_pause;
        logic     ts_stop;
        o = '0;
        ts_pause = (c.task_status == TS_PAUSING) || (c.task_status == TS_PAUSED);
        ts_stop = (c.task_status == TS_STOPPING) || (c.task_status == TS_STOPPED);
        case (c.func)
            FUNC_TICK: begin
                if (seq_task_present && seq_owner == OWNER_RECOVERY) begin
                    case (seq_mode)
                        MODE_MOVING: begin
                            o.ctrl_step = 1'b1;
                            if (c.ctrl_stopped) begin
                                o.signal_out = SIG_STOPPED;
                                seq_mode = MODE_STOPPED;
                            end else if (c.ctrl_recover_over) begin
                                o.task_call = TCALL_RESUME;
                                if (c.task_ack) begin
                                    seq_owner = OWNER_TASK;
                                    seq_mode = MODE_RESUMING;
                                end
                            end
                        end
                        MODE_PAUSING: begin
                            o.ctrl_step = 1'b1;
                            if (c.ctrl_recover_paused) begin
                                o.signal_out = SIG_PAUSED;
                                seq_mode = MODE_PAUSED;
                            end
                        end
                        MODE_STOPPING: begin
                            o.ctrl_step = 1'b1;
                            if (c.ctrl_stopped) begin
                                o.signal_out = SIG_STOPPED;
                                seq_mode = MODE_STOPPED;
                                seq_owner = OWNER_TASK;
                            end
                        end
                        default: ;
                    endcase
                end else if (seq_task_present) begin
                    case (seq_mode)
                        MODE_MOVING: begin
                            o.task_step = 1'b1;
                            if (ts_pause)
                                seq_mode = MODE_PAUSING;
                            else if (ts_stop)
                                seq_mode = MODE_STOPPING;
                        end
                        MODE_PAUSING: begin
                            o.task_step = 1'b1;
                            if (c.task_status == TS_PAUSED) begin
                                o.signal_out = SIG_PAUSED;
                                o.ctrl_call = CCALL_INIT;
                                seq_mode = MODE_PAUSED;
                            end else if (ts_stop) begin
                                seq_mode = MODE_STOPPING;
                            end else if (c.task_status == TS_RUNNING) begin
                                seq_mode = MODE_RESUMING;
                            end
                        end
                        MODE_PAUSED: o.ctrl_step = 1'b1;
                        MODE_RESUMING: begin
                            o.task_step = 1'b1;
                            if (c.task_status == TS_RUNNING) begin
                                o.signal_out = SIG_RESUMED;
                                seq_mode = MODE_MOVING;
                            end else if (ts_stop) begin
                                o.signal_out = SIG_RESUMED;
                                seq_mode = MODE_STOPPING;
                            end else if (ts_pause) begin
                                seq_mode = MODE_PAUSING;
                            end
                        end
                        MODE_STOPPING: begin
                            o.task_step = 1'b1;
                            if (c.task_status == TS_STOPPED) begin
                                o.signal_out = SIG_STOPPED;
                                seq_mode = MODE_STOPPED;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            FUNC_PAUSE: begin
                if (seq_task_present && seq_owner == OWNER_RECOVERY) begin
                    if (seq_mode == MODE_PAUSED || seq_mode == MODE_PAUSING) begin
                        o.ok = 1'b1;
                    end else if (seq_mode == MODE_MOVING) begin
                        o.ctrl_call = CCALL_PAUSE_REC;
                        o.ok = c.ctrl_ack;
                        if (c.ctrl_ack)
                            seq_mode = MODE_PAUSING;
                    end
                end else if (seq_task_present) begin
                    if (seq_mode == MODE_MOVING || seq_mode == MODE_RESUMING) begin
                        o.task_call = TCALL_PAUSE;
                        o.ok = c.task_ack;
                        if (c.task_ack)
                            seq_mode = MODE_PAUSING;
                    end else if (seq_mode == MODE_PAUSING || seq_mode == MODE_PAUSED) begin
                        o.ok = 1'b1;
                    end
                end
            end
            FUNC_RESUME: begin
                if (seq_task_present && seq_owner == OWNER_RECOVERY) begin
                    if (seq_mode == MODE_MOVING) begin
                        o.ok = 1'b1;
                    end else if (seq_mode == MODE_PAUSED) begin
                        o.ctrl_call = CCALL_RESUME_REC;
                        o.ok = c.ctrl_ack;
                        if (c.ctrl_ack) begin
                            seq_mode = MODE_MOVING;
                            o.signal_out = SIG_RESUMED;
                        end
                    end
                end else if (seq_task_present) begin
                    if (seq_mode == MODE_PAUSED) begin
                        o.ctrl_call = CCALL_ACTIVATE;
                        o.ok = c.ctrl_ack;
                        if (c.ctrl_ack) begin
                            seq_owner = OWNER_RECOVERY;
                            seq_mode = MODE_MOVING;
                            o.signal_out = SIG_RESUMED;
                        end
                    end else if (seq_mode == MODE_RESUMING) begin
                        o.ok = 1'b1;
                    end
                end
            end
            FUNC_STOP: begin
                if (seq_task_present && seq_owner == OWNER_RECOVERY) begin
                    if (seq_mode == MODE_STOPPING) begin
                        o.ok = 1'b1;
                    end else if (seq_mode == MODE_MOVING || seq_mode == MODE_PAUSING ||
                                 seq_mode == MODE_PAUSED) begin
                        o.ctrl_call = CCALL_STOP;
                        o.stop_now = c.immediate_stop;
                        o.ok = c.ctrl_ack;
                        if (c.ctrl_ack)
                            seq_mode = MODE_STOPPING;
                    end
                end else if (seq_task_present) begin
                    if (seq_mode == MODE_MOVING || seq_mode == MODE_RESUMING ||
                        seq_mode == MODE_PAUSING) begin
                        o.task_call = TCALL_STOP;
                        o.stop_now = c.immediate_stop;
                        o.ok = c.task_ack;
                        if (c.task_ack)
                            seq_mode = MODE_STOPPING;
                    end else if (seq_mode == MODE_PAUSED) begin
                        seq_mode = MODE_STOPPED;
                        o.ok = 1'b1;
                    end else if (seq_mode == MODE_STOPPING || seq_mode == MODE_STOPPED) begin
                        o.ok = 1'b1;
                    end
                end
            end
            FUNC_RESTART: begin
                seq_task_present = 1'b1;
                seq_mode = MODE_MOVING;
                seq_owner = OWNER_TASK;
                o.ok = 1'b1;
            end
            FUNC_RESET: begin
                // owner is kept across a reset command
                seq_task_present = 1'b0;
                seq_mode = MODE_STOPPED;
                o.ctrl_call = CCALL_INIT;
            end
            default: begin
                if (seq_mode == MODE_PAUSED && seq_owner == OWNER_TASK) begin
                    o.ok = c.ctrl_ack;
                    if (c.func == FUNC_PM_START) begin
                        o.ctrl_call = CCALL_PM_START;
                    end else begin
                        o.ctrl_call = CCALL_PM_STOP;
                        o.stop_now = c.immediate_stop;
                    end
                end
            end
        endcase
        o.mode_out = seq_mode;
        o.owner_out = seq_owner;
        return o;
    endfunction

    function automatic command_t random_command(func_t f);
        command_t c;
        c.func = f;
        c.task_status = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
                                                 : 3'($urandom_range(4));
        c.task_ack = ($urandom_range(6) != 0);
        c.ctrl_ack = ($urandom_range(6) != 0);
        c.ctrl_stopped = ($urandom_range(3) == 0);
        c.ctrl_recover_over = 1'($urandom_range(1));
        c.ctrl_recover_paused = 1'($urandom_range(1));
        c.immediate_stop = 1'($urandom_range(1));
        return c;
    endfunction

    function automatic func_t random_func();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40) return FUNC_TICK;
        if (r < 52) return FUNC_PAUSE;
        if (r < 64) return FUNC_RESUME;
        if (r < 74) return FUNC_STOP;
        if (r < 80) return FUNC_RESTART;
        if (r < 84) return FUNC_RESET;
        if (r < 92) return FUNC_PM_START;
        return FUNC_PM_STOP;
    endfunction

    task automatic queue_command(command_t c);
        command_q.push_back(c);
        queued_count++;
    endtask

    // flags: {task_ack, ctrl_ack, ctrl_stopped, ctrl_recover_over, ctrl_recover_paused,
    // immediate_stop}
    task automatic push_cmd(func_t f, logic [2:0] ts, logic [5:0] flags);
        queue_command({f, ts, flags});
    endtask

    task automatic queue_tick(logic [2:0] ts);
        command_t c;
        c = random_command(FUNC_TICK);
        c.task_status = ts;
        queue_command(c);
    endtask

    // Well-formed run: start, pause, point moves, then stop, or hand over to recovery and
    // end with a return to the task, a stop or a reset. Random acks still break some of them.
    task automatic queue_recovery_cycle();
        command_t c;
        queue_command(random_command(FUNC_RESTART));
        repeat ($urandom_range(2)) queue_tick(TS_RUNNING);
        queue_command(random_command(FUNC_PAUSE));
        queue_tick(TS_PAUSING);
        queue_tick(TS_PAUSED);
        repeat ($urandom_range(2))
            queue_command(random_command($urandom_range(1) ? FUNC_PM_START : FUNC_PM_STOP));
        if ($urandom_range(3) == 0) begin
            queue_command(random_command(FUNC_STOP));
        end else begin
            queue_command(random_command(FUNC_RESUME));
            if ($urandom_range(1)) begin
                queue_command(random_command(FUNC_PAUSE));
                c = random_command(FUNC_TICK);
                c.ctrl_stopped = 1'b0;
                c.ctrl_recover_paused = 1'b1;
                queue_command(c);
                queue_command(random_command(FUNC_RESUME));
            end
            c = random_command(FUNC_TICK);
            case ($urandom_range(2))
                0: begin
                    c.ctrl_stopped = 1'b0;
                    c.ctrl_recover_over = 1'b1;
                    queue_command(c);
                    queue_tick($urandom_range(1) ? TS_RUNNING : TS_STOPPING);
                end
                1: begin
                    queue_command(random_command(FUNC_STOP));
                    c.ctrl_stopped = 1'b1;
                    queue_command(c);
                end
                default: begin
                    c.ctrl_stopped = 1'b1;
                    queue_command(c);
                    queue_command(random_command(FUNC_RESET));
                end
            endcase
        end
    endtask

    task automatic fill_random(int unsigned count);
        int unsigned target;
        target = queued_count + count;
        while (queued_count < target) begin
            if ($urandom_range(1))
                queue_recovery_cycle();
            else
                repeat (6) queue_command(random_command(random_func()));
        end
    endtask

    // Hold until every queued word is taken and every result has come back.
    task automatic wait_drained();
        while (command_q.size() != 0 || s_valid || outcome_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid)
                outcome_q.push_back(sequence_command(s_cmd));
            if (command_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                s_cmd <= command_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (outcome_q.size() == 0) begin
                    $error("result word with no command pending");
                    mismatch_count++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("ok", want.ok, m_ok);
                    check_field("task_step", want.task_step, m_task_step);
                    check_field("ctrl_step", want.ctrl_step, m_ctrl_step);
                    check_field("task_call", want.task_call, m_task_call);
                    check_field("ctrl_call", want.ctrl_call, m_ctrl_call);
                    check_field("stop_now", want.stop_now, m_stop_now);
                    check_field("signal_out", want.signal_out, m_signal_out);
                    check_field("mode_out", want.mode_out, m_mode_out);
                    check_field("owner_out", want.owner_out, m_owner_out);
                end
            end
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        while (!aresetn) @(negedge aclk);

        // no task yet: everything refused or ignored
        push_cmd(FUNC_TICK, 3'd0, 6'b000000);
        push_cmd(FUNC_PAUSE, TS_RUNNING, 6'b110000);
        push_cmd(FUNC_RESUME, TS_RUNNING, 6'b010000);
        push_cmd(FUNC_STOP, TS_RUNNING, 6'b110001);
        push_cmd(FUNC_PM_START, TS_RUNNING, 6'b010000);
        // task walk: unknown status, pause and resume on its own
        push_cmd(FUNC_RESTART, TS_RUNNING, 6'b000000);
        push_cmd(FUNC_TICK, 3'd7, 6'b111110);
        push_cmd(FUNC_TICK, TS_PAUSING, 6'b000000);
        push_cmd(FUNC_TICK, TS_RUNNING, 6'b000000);
        push_cmd(FUNC_TICK, TS_RUNNING, 6'b000000);
        push_cmd(FUNC_PAUSE, TS_RUNNING, 6'b010000);
        push_cmd(FUNC_PAUSE, TS_RUNNING, 6'b100000);
        push_cmd(FUNC_TICK, TS_PAUSED, 6'b000000);
        // point moves while paused, the recovery hand-over and back, then stop and reset
        push_cmd(FUNC_PM_START, TS_RUNNING, 6'b010000);
        push_cmd(FUNC_PM_STOP, 3'd7, 6'b111111);
        push_cmd(FUNC_TICK, TS_RUNNING, 6'b000000);
        push_cmd(FUNC_RESUME, TS_RUNNING, 6'b010000);
        push_cmd(FUNC_PAUSE, TS_RUNNING, 6'b010000);
        push_cmd(FUNC_TICK, TS_RUNNING, 6'b000010);
        push_cmd(FUNC_RESUME, TS_RUNNING, 6'b010000);
        push_cmd(FUNC_TICK, TS_RUNNING, 6'b100100);
        push_cmd(FUNC_TICK, TS_STOPPING, 6'b000000);
        push_cmd(FUNC_TICK, TS_STOPPED, 6'b000000);
        push_cmd(FUNC_STOP, TS_RUNNING, 6'b000001);
        push_cmd(FUNC_RESET, TS_RUNNING, 6'b000000);

        fill_random(285);
        wait_drained();

        sender_idle_pct = 49;
        receiver_idle_pct = 12;
        fill_random(285);
        wait_drained();

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        fill_random(285);
        wait_drained();

        // let any stray result word surface
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* auto_task_mode_sequencer.f */
+incdir+src
src/atms_pkg.sv
src/auto_task_mode_sequencer.sv
tb/testbench.sv
